@@ rtl/dpm_pkg.sv @@
// Shared types, constants and defaults for the demand-paged memory with hammer watch.
package dpm_pkg;

	// default geometry (MEMORY_BYTES and PAGE_BYTES are powers of two)
	localparam int MEMORY_BYTES_DEF = 1024;
	localparam int FRAME_COUNT_DEF  = 16;
	localparam int PAGE_BYTES_DEF   = 64;

	// fixed field widths
	localparam int ADDR_W     = 10;
	localparam int DATA_W     = 8;
	localparam int STAT_W     = 2;
	localparam int FRAME_O_W  = 4;
	localparam int CNT_W      = 32;
	localparam int TICK_W     = 32;
	localparam int TOT_W      = 64;
	localparam int THR_W      = 32;
	localparam int WIN_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// register reset values and the access count ceiling
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000);
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_FAULT   = 2'd2,
		ST_NOFRAME = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_XLATE,
		S_UPDATE
	} state_t;

	// page table control from the sequencer
	typedef struct packed {
		logic clear;
		logic lookup;
		logic resolve;
		logic is_write;
	} page_ctl_t;

	// page table answer during resolve
	typedef struct packed {
		logic mapped;
		logic alloc;
	} page_res_t;

	// frame table control from the sequencer
	typedef struct packed {
		logic clear;
		logic lookup;
		logic commit;
	} frame_ctl_t;

	// one frame table entry
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [TICK_W-1:0] last;
	} frame_ent_t;

endpackage

@@ rtl/dpm_page_table.sv @@
// Page table memory, used-frame map and lowest-free-frame allocator.
module dpm_page_table #(
	parameter int PAGE_COUNT  = dpm_pkg::MEMORY_BYTES_DEF / dpm_pkg::PAGE_BYTES_DEF,
	parameter int FRAME_COUNT = dpm_pkg::FRAME_COUNT_DEF,
	localparam int PG_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
	localparam int FR_W = $clog2(FRAME_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dpm_pkg::page_ctl_t  ctl,
	input  logic [PG_W-1:0]     page,
	input  logic [PG_W-1:0]     clr_page,
	output dpm_pkg::page_res_t  res,
	output logic [FR_W-1:0]     frame
);

	// entry: {valid, frame}
	logic [FR_W:0]          mem [PAGE_COUNT];
	logic [FR_W:0]          rd_q;
	logic [FRAME_COUNT-1:0] used_q;
	logic                   free_found;
	logic [FR_W-1:0]        free_idx;

	// lowest free frame
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = FR_W'(i);
			end
		end
	end

	// translation or allocation from the registered entry
	always_comb begin
		res.alloc  = ctl.resolve && ctl.is_write && !rd_q[FR_W] && free_found;
		res.mapped = rd_q[FR_W] || res.alloc;
		frame      = rd_q[FR_W] ? rd_q[FR_W-1:0] : free_idx;
	end

	// table memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			mem[clr_page] <= '0;
		end else if (res.alloc) begin
			mem[page] <= {1'b1, free_idx};
		end
		if (ctl.lookup) begin
			rd_q <= mem[page];
		end
	end

	// frames are never freed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (res.alloc) begin
			used_q[free_idx] <= 1'b1;
		end
	end

	allocated_frame_was_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.alloc |-> !used_q[free_idx])
		else $error("allocator picked a used frame");

endmodule

@@ rtl/dpm_frame_table.sv @@
// Per-frame access counts and last-access ticks, with the hammer check.
module dpm_frame_table #(
	parameter int FRAME_COUNT = dpm_pkg::FRAME_COUNT_DEF,
	localparam int FR_W = $clog2(FRAME_COUNT)
) (
	input  logic                          clk,
	input  dpm_pkg::frame_ctl_t           ctl,
	input  logic [FR_W-1:0]               frame,
	input  logic [FR_W-1:0]               clr_frame,
	input  logic [dpm_pkg::TICK_W-1:0]    now_tick,
	input  logic [dpm_pkg::THR_W-1:0]     threshold,
	input  logic [dpm_pkg::WIN_W-1:0]     window,
	output logic [dpm_pkg::CNT_W-1:0]     count_new,
	output logic                          hot
);

	dpm_pkg::frame_ent_t              mem [FRAME_COUNT];
	dpm_pkg::frame_ent_t              rd_q;
	logic [dpm_pkg::TICK_W-1:0]       gap;

	// saturating count and rapid-access test
	always_comb begin
		count_new = (rd_q.count == dpm_pkg::CNT_MAX) ? rd_q.count : rd_q.count + 1'b1;
		gap       = now_tick - rd_q.last;
		hot       = (count_new > threshold) && (gap < dpm_pkg::TICK_W'(window));
	end

	// read-modify-write memory
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			mem[clr_frame] <= '0;
		end else if (ctl.commit) begin
			mem[frame] <= '{count: count_new, last: now_tick};
		end
		if (ctl.lookup) begin
			rd_q <= mem[frame];
		end
	end

endmodule

@@ rtl/dpm_byte_store.sv @@
// Physical byte memory with one write port and one registered read port.
module dpm_byte_store #(
	parameter int MEMORY_BYTES = dpm_pkg::MEMORY_BYTES_DEF,
	localparam int MA_W = $clog2(MEMORY_BYTES)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [MA_W-1:0]            wr_addr,
	input  logic [dpm_pkg::DATA_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [MA_W-1:0]            rd_addr,
	output logic [dpm_pkg::DATA_W-1:0] rd_data
);

	logic [dpm_pkg::DATA_W-1:0] mem [MEMORY_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/demand_paged_memory_with_hammer_watch_core.sv @@
// Steps per word, set by the sequencer: page table read, then frame table and byte store
// read, then write back and result load. Write-back waits while an earlier result word
// is still held by out_stall, and the next word is accepted only after the write-back.
// A waiting result word does not block acceptance of the next input word.
// Reset: asynchronous; the block then sweeps the byte store, page table and
// frame table to zero over every byte address, with in_stall high.
module demand_paged_memory_with_hammer_watch_core #(
	parameter int MEMORY_BYTES = dpm_pkg::MEMORY_BYTES_DEF,
	parameter int FRAME_COUNT  = dpm_pkg::FRAME_COUNT_DEF,
	parameter int PAGE_BYTES   = dpm_pkg::PAGE_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_write,
	input  logic [dpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dpm_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      operation,
	input  logic [dpm_pkg::ADDR_W-1:0]      address,
	input  logic [dpm_pkg::DATA_W-1:0]      write_data,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [dpm_pkg::STAT_W-1:0]      status,
	output logic [dpm_pkg::DATA_W-1:0]      read_byte,
	output logic [dpm_pkg::FRAME_O_W-1:0]   frame_used,
	output logic                            hammer_warning,
	output logic [dpm_pkg::CNT_W-1:0]       frame_access_total,
	output logic [dpm_pkg::TOT_W-1:0]       hit_total,
	output logic [dpm_pkg::TOT_W-1:0]       miss_total,
	output logic [dpm_pkg::TOT_W-1:0]       read_total,
	output logic [dpm_pkg::TOT_W-1:0]       write_total
);

	localparam int PAGE_COUNT = MEMORY_BYTES / PAGE_BYTES;
	localparam int PG_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int FR_W       = $clog2(FRAME_COUNT);
	localparam int MA_W       = $clog2(MEMORY_BYTES);
	localparam int OFF_W      = $clog2(PAGE_BYTES);
	localparam logic [MA_W-1:0] SWEEP_LAST = MA_W'(MEMORY_BYTES - 1);

	// sequencer and item registers
	dpm_pkg::state_t               state_q, state_d;
	dpm_pkg::op_t                  op_q;
	logic [dpm_pkg::ADDR_W-1:0]    addr_q;
	logic [dpm_pkg::DATA_W-1:0]    data_q;
	logic [FR_W-1:0]               frame_q;
	logic                          mapped_q;
	dpm_pkg::status_t              stat_q;
	logic [MA_W-1:0]               sweep_q;

	// architectural registers
	logic [dpm_pkg::THR_W-1:0]     thr_q;
	logic [dpm_pkg::WIN_W-1:0]     win_q;
	logic [dpm_pkg::TICK_W-1:0]    tick_q;
	logic [dpm_pkg::TOT_W-1:0]     hit_q, miss_q, rd_cnt_q, wr_cnt_q;

	// result register
	logic                          out_valid_q;
	dpm_pkg::status_t              status_q;
	logic [dpm_pkg::DATA_W-1:0]    read_byte_q;
	logic [dpm_pkg::FRAME_O_W-1:0] frame_used_q;
	logic                          warn_q;
	logic [dpm_pkg::CNT_W-1:0]     ftotal_q;

	// datapath
	dpm_pkg::page_ctl_t            page_ctl;
	dpm_pkg::page_res_t            page_res;
	dpm_pkg::frame_ctl_t           frame_ctl;
	logic [FR_W-1:0]               pt_frame;
	logic [FR_W-1:0]               ft_frame;
	logic [dpm_pkg::CNT_W-1:0]     count_new;
	logic                          hot;
	logic [dpm_pkg::DATA_W-1:0]    bs_rdata;
	logic                          bs_wr, bs_rd;
	logic [MA_W-1:0]               bs_waddr, bs_raddr;
	logic [dpm_pkg::DATA_W-1:0]    bs_wdata;
	logic [31:0]                   addr_in_ext, addr_q_ext;
	logic [PG_W-1:0]               page_sel;
	logic                          access_q, in_range_q;
	logic                          finish, in_take;

	// address split (both sizes are powers of two)
	always_comb begin
		addr_in_ext = 32'(address);
		addr_q_ext  = 32'(addr_q);
		page_sel    = (state_q == dpm_pkg::S_IDLE) ? PG_W'(addr_in_ext >> OFF_W)
		                                           : PG_W'(addr_q_ext >> OFF_W);
		access_q    = (op_q == dpm_pkg::OP_WRITE) || (op_q == dpm_pkg::OP_READ);
		in_range_q  = addr_q_ext < 32'(MEMORY_BYTES);
	end

	// physical address: frame, then offset, modulo store size
	function automatic logic [MA_W-1:0] phys_addr(input logic [FR_W-1:0] f,
	                                              input logic [31:0] a);
		logic [31:0] off;
		off       = a & ((32'd1 << OFF_W) - 32'd1);
		phys_addr = MA_W'((32'(f) << OFF_W) | off);
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dpm_pkg::S_CLEAR:  if (sweep_q == SWEEP_LAST) state_d = dpm_pkg::S_IDLE;
			dpm_pkg::S_IDLE:   if (in_valid) state_d = dpm_pkg::S_XLATE;
			dpm_pkg::S_XLATE:  state_d = dpm_pkg::S_UPDATE;
			dpm_pkg::S_UPDATE: if (!out_valid_q || !out_stall) state_d = dpm_pkg::S_IDLE;
			default:           state_d = dpm_pkg::S_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != dpm_pkg::S_IDLE);
		in_take   = (state_q == dpm_pkg::S_IDLE) && in_valid;
		finish    = (state_q == dpm_pkg::S_UPDATE) && (!out_valid_q || !out_stall);

		page_ctl.clear    = (state_q == dpm_pkg::S_CLEAR) && (32'(sweep_q) < 32'(PAGE_COUNT));
		page_ctl.lookup   = in_take;
		page_ctl.resolve  = (state_q == dpm_pkg::S_XLATE) && access_q && in_range_q;
		page_ctl.is_write = (op_q == dpm_pkg::OP_WRITE);

		frame_ctl.clear  = (state_q == dpm_pkg::S_CLEAR) && (32'(sweep_q) < 32'(FRAME_COUNT));
		frame_ctl.lookup = page_ctl.resolve && page_res.mapped;
		frame_ctl.commit = finish && mapped_q;
		ft_frame         = frame_ctl.clear ? FR_W'(sweep_q)
		                 : ((state_q == dpm_pkg::S_XLATE) ? pt_frame : frame_q);

		bs_rd    = frame_ctl.lookup && (op_q == dpm_pkg::OP_READ);
		bs_raddr = phys_addr(pt_frame, addr_q_ext);
		bs_wr    = (state_q == dpm_pkg::S_CLEAR) ||
		           (finish && mapped_q && (op_q == dpm_pkg::OP_WRITE));
		bs_waddr = (state_q == dpm_pkg::S_CLEAR) ? sweep_q : phys_addr(frame_q, addr_q_ext);
		bs_wdata = (state_q == dpm_pkg::S_CLEAR) ? '0 : data_q;
	end

	dpm_page_table #(
		.PAGE_COUNT  (PAGE_COUNT),
		.FRAME_COUNT (FRAME_COUNT)
	) u_page_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (page_ctl),
		.page     (page_sel),
		.clr_page (PG_W'(sweep_q)),
		.res      (page_res),
		.frame    (pt_frame)
	);

	dpm_frame_table #(
		.FRAME_COUNT (FRAME_COUNT)
	) u_frame_table (
		.clk       (clk),
		.ctl       (frame_ctl),
		.frame     (ft_frame),
		.clr_frame (FR_W'(sweep_q)),
		.now_tick  (tick_q),
		.threshold (thr_q),
		.window    (win_q),
		.count_new (count_new),
		.hot       (hot)
	);

	dpm_byte_store #(
		.MEMORY_BYTES (MEMORY_BYTES)
	) u_byte_store (
		.clk     (clk),
		.wr_en   (bs_wr),
		.wr_addr (bs_waddr),
		.wr_data (bs_wdata),
		.rd_en   (bs_rd),
		.rd_addr (bs_raddr),
		.rd_data (bs_rdata)
	);

	// item capture and translation result
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q   <= dpm_pkg::op_t'(operation);
			addr_q <= address;
			data_q <= write_data;
		end
		if (state_q == dpm_pkg::S_XLATE) begin
			frame_q  <= pt_frame;
			mapped_q <= page_ctl.resolve && page_res.mapped;
			priority if (!access_q)                      stat_q <= dpm_pkg::ST_OK;
			else if (!in_range_q)                        stat_q <= dpm_pkg::ST_RANGE;
			else if (page_res.mapped)                    stat_q <= dpm_pkg::ST_OK;
			else if (op_q == dpm_pkg::OP_READ)           stat_q <= dpm_pkg::ST_FAULT;
			else                                         stat_q <= dpm_pkg::ST_NOFRAME;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (finish) begin
			status_q     <= stat_q;
			read_byte_q  <= (mapped_q && op_q == dpm_pkg::OP_READ) ? bs_rdata : '0;
			frame_used_q <= mapped_q ? dpm_pkg::FRAME_O_W'(32'(frame_q)) : '0;
			warn_q       <= mapped_q && hot;
			ftotal_q     <= mapped_q ? count_new : '0;
		end
	end

	// control, counters and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpm_pkg::S_CLEAR;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
			thr_q       <= dpm_pkg::THR_RESET;
			win_q       <= dpm_pkg::WIN_RESET;
			tick_q      <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			rd_cnt_q    <= '0;
			wr_cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dpm_pkg::S_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					dpm_pkg::CFG_THRESHOLD: thr_q <= cfg_data;
					dpm_pkg::CFG_WINDOW:    win_q <= cfg_data[dpm_pkg::WIN_W-1:0];
					default: ;
				endcase
			end
			if (finish) begin
				if (op_q == dpm_pkg::OP_TICK) begin
					tick_q <= tick_q + 1'b1;
				end
				if (access_q && in_range_q) begin
					if (op_q == dpm_pkg::OP_READ) rd_cnt_q <= rd_cnt_q + 1'b1;
					else                          wr_cnt_q <= wr_cnt_q + 1'b1;
					if (mapped_q) hit_q  <= hit_q + 1'b1;
					else          miss_q <= miss_q + 1'b1;
				end
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign read_byte          = read_byte_q;
	assign frame_used         = frame_used_q;
	assign hammer_warning     = warn_q;
	assign frame_access_total = ftotal_q;
	assign hit_total          = hit_q;
	assign miss_total         = miss_q;
	assign read_total         = rd_cnt_q;
	assign write_total        = wr_cnt_q;

	// a result word appears only from the write-back step
	result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == dpm_pkg::S_UPDATE)
		else $error("result word loaded outside write-back");

	// a waiting result is never overwritten
	hold_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dpm_pkg::S_UPDATE && out_valid_q && out_stall) |=>
		(state_q == dpm_pkg::S_UPDATE && $stable(status_q) && $stable(ftotal_q)))
		else $error("blocked result word changed");

	// a hit is counted only with a successful result word
	hit_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q != $past(hit_q)) |-> (out_valid_q && status_q == dpm_pkg::ST_OK))
		else $error("hit counted without successful access");

	// translation never reports a frame for an out-of-range access
	no_map_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dpm_pkg::S_XLATE && !in_range_q) |=> !mapped_q)
		else $error("out-of-range access mapped");

endmodule
